>>> hw/rtl/irut_pkg.sv
// Shared types and constants for the IR carrier UART transmitter.
// No dependencies; imported by every module of the block.
package irut_pkg;

   localparam int BitTimerWidth  = 20;
   localparam int CarrierWidth   = 16;
   localparam int ByteWidth      = 8;
   localparam int PosWidth       = 4;
   localparam int RspDataWidth   = 8;

   localparam logic [BitTimerWidth-1:0] BitPeriodReset      = 20'd27586;
   localparam logic [CarrierWidth-1:0]  CarrierCompareReset = 16'd210;

   // configuration register indexes
   localparam logic CsrBitPeriod      = 1'b0;
   localparam logic CsrCarrierCompare = 1'b1;

   // request kinds carried on tuser
   localparam logic OpTick = 1'b0;
   localparam logic OpSend = 1'b1;

   // frame status handed from the framer to the carrier and output stage
   typedef struct packed {
      logic carrier_en;
      logic sending;
      logic accepted;
   } frame_status_type;

endpackage

>>> hw/rtl/ir_carrier_uart_transmitter_unit.sv
// IR carrier UART transmitter, top level: input register, framer, carrier, result register.
// A request beat passes the input then the result register; one beat per cycle unless
// the result channel stalls, set by the single-tick update of frame and carrier counters.
// Synchronous active-high reset clears control state, pin low, idle, registers to defaults.
module ir_carrier_uart_transmitter_unit #(
   parameter int DATA_BITS = 8
) (
   input  logic                                  clock,
   input  logic                                  reset,
   // request channel
   input  logic                                  req_tvalid,
   output logic                                  req_tready,
   input  logic [irut_pkg::ByteWidth-1:0]        req_tdata,  // [7:0] data_byte
   input  logic                                  req_tuser,  // [0] operation
   // result channel
   output logic                                  rsp_tvalid,
   input  logic                                  rsp_tready,
   output logic [irut_pkg::RspDataWidth-1:0]     rsp_tdata,  // [0] ir_level, [1] busy_res,
                                                             // [2] accepted, [7:3] zero
   // configuration write channel
   input  logic                                  csr_valid,
   output logic                                  csr_ready,
   input  logic                                  csr_index,
   input  logic [irut_pkg::BitTimerWidth-1:0]    csr_wdata
);
   import irut_pkg::*;

   logic [BitTimerWidth-1:0] bit_period_ff;
   logic [CarrierWidth-1:0]  carrier_compare_ff;

   logic                     in_valid_ff;
   logic                     in_op_ff;
   logic [ByteWidth-1:0]     in_byte_ff;

   logic                     rsp_valid_ff;
   logic [RspDataWidth-1:0]  rsp_data_ff;

   logic                     fire;
   logic                     pin_next;
   frame_status_type         status;

   // configuration registers
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         bit_period_ff      <= BitPeriodReset;
         carrier_compare_ff <= CarrierCompareReset;
      end else if (csr_valid) begin
         case (csr_index)
            CsrBitPeriod:      bit_period_ff      <= csr_wdata;
            CsrCarrierCompare: carrier_compare_ff <= csr_wdata[CarrierWidth-1:0];
            default:           bit_period_ff      <= bit_period_ff;
         endcase
      end
   end

   // process the held beat when the result register can take it
   assign fire       = in_valid_ff && (!rsp_valid_ff || rsp_tready);
   assign req_tready = !in_valid_ff || fire;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_tready) begin
         in_valid_ff <= req_tvalid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_tready && req_tvalid) begin
         in_op_ff   <= req_tuser;
         in_byte_ff <= req_tdata;
      end
   end

   irut_frame #(
      .DATA_BITS (DATA_BITS)
   ) u_frame (
      .clock      (clock),
      .reset      (reset),
      .tick       (fire),
      .op         (in_op_ff),
      .byte_in    (in_byte_ff),
      .bit_period (bit_period_ff),
      .status     (status)
   );

   irut_carrier u_carrier (
      .clock           (clock),
      .reset           (reset),
      .tick            (fire),
      .carrier_en      (status.carrier_en),
      .carrier_compare (carrier_compare_ff),
      .pin_next        (pin_next)
   );

   // result register: hold until taken
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (fire) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (fire) begin
         rsp_data_ff <= {5'b0, status.accepted, status.sending, pin_next};
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

endmodule

>>> hw/rtl/irut_frame.sv
// 8N1 framer: start bit, data bits LSB first, stop bit, timed in ticks.
// Depends on irut_pkg; feeds next carrier enable and status to the top level.
module irut_frame #(
   parameter int DATA_BITS = 8
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 tick,
   input  logic                                 op,
   input  logic [irut_pkg::ByteWidth-1:0]       byte_in,
   input  logic [irut_pkg::BitTimerWidth-1:0]   bit_period,
   output irut_pkg::frame_status_type           status
);
   import irut_pkg::*;

   localparam logic [PosWidth-1:0] LastPos = PosWidth'(DATA_BITS);

   logic [ByteWidth-1:0]     shift_ff, shift_in;
   logic [PosWidth-1:0]      pos_ff, pos_in, pos_inc;
   logic [BitTimerWidth-1:0] timer_ff, timer_in, timer_inc;
   logic                     en_ff, en_in;
   logic                     sending_ff, sending_in;
   logic                     accepted;

   assign timer_inc = timer_ff + BitTimerWidth'(1);
   assign pos_inc   = pos_ff + PosWidth'(1);

   // next frame state for one tick
   always_comb begin
      shift_in   = shift_ff;
      pos_in     = pos_ff;
      timer_in   = timer_ff;
      en_in      = en_ff;
      sending_in = sending_ff;
      accepted   = 1'b0;
      if (!sending_ff) begin
         if (op == OpSend) begin
            accepted   = 1'b1;
            shift_in   = byte_in;
            pos_in     = '0;
            timer_in   = '0;
            sending_in = 1'b1;
            en_in      = 1'b1;
         end
      end else if (timer_inc < bit_period) begin
         timer_in = timer_inc;
      end else begin
         timer_in = '0;
         if (pos_ff > LastPos) begin
            // stop bit done: go idle
            sending_in = 1'b0;
            en_in      = 1'b0;
            pos_in     = '0;
         end else begin
            pos_in = pos_inc;
            if (pos_inc <= LastPos) begin
               en_in    = ~shift_ff[0];
               shift_in = {1'b0, shift_ff[ByteWidth-1:1]};
            end else begin
               en_in = 1'b0;
            end
         end
      end
   end

   // advance on each accepted tick
   always_ff @(posedge clock) begin
      if (reset) begin
         shift_ff   <= '0;
         pos_ff     <= '0;
         timer_ff   <= '0;
         en_ff      <= 1'b0;
         sending_ff <= 1'b0;
      end else if (tick) begin
         shift_ff   <= shift_in;
         pos_ff     <= pos_in;
         timer_ff   <= timer_in;
         en_ff      <= en_in;
         sending_ff <= sending_in;
      end
   end

   assign status.carrier_en = en_in;
   assign status.sending    = sending_in;
   assign status.accepted   = accepted;

endmodule

>>> hw/rtl/irut_carrier.sv
// Carrier generator: free-running compare counter that toggles or clears the pin.
// Depends on irut_pkg; uses the framer's next carrier enable.
module irut_carrier (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               tick,
   input  logic                               carrier_en,
   input  logic [irut_pkg::CarrierWidth-1:0]  carrier_compare,
   output logic                               pin_next
);
   import irut_pkg::*;

   logic [CarrierWidth-1:0] timer_ff, timer_in;
   logic                    pin_ff;

   // on a compare match toggle while on, force low while off
   always_comb begin
      if (timer_ff >= carrier_compare) begin
         timer_in = '0;
         pin_next = carrier_en ? ~pin_ff : 1'b0;
      end else begin
         timer_in = timer_ff + CarrierWidth'(1);
         pin_next = pin_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         timer_ff <= '0;
         pin_ff   <= 1'b0;
      end else if (tick) begin
         timer_ff <= timer_in;
         pin_ff   <= pin_next;
      end
   end

endmodule
